// ----- sv/hht_pkg.sv -----
package hht_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_DUP     = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FIND_RD,
    S_FIND_KEY,
    S_FIND_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_DEL_RD,
    S_DEL_KEY,
    S_DEL_LOAD,
    S_DEL_HASH,
    S_DEL_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } hash_ctl_t;

  localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;

endpackage

// ----- sv/hht_hash.sv -----
module hht_hash
  import hht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] key,
  output hash_ctl_t   ctl,
  output logic [31:0] hash
);

  logic [31:0] acc;
  logic [1:0]  round;
  logic        busy;
  logic [31:0] mixed;

  assign mixed = acc ^ (acc >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
    end else if (start) begin
      busy <= 1'b1;
      round <= '0;
      acc <= key;
    end else if (busy) begin
      if (round == 2'd2) begin
        acc <= mixed;
        busy <= 1'b0;
      end else begin
        acc <= mixed * HASH_MUL;
        round <= round + 2'd1;
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy | start;
  assign hash = acc;

endmodule

// ----- sv/handle_hash_table_core.sv -----
// channel | dir | tdata fields (low first)                          | tuser
// s_axis  | in  | mode[1:0] handle[33:2] res_type[41:34], pad to 48  | -
// m_axis  | out | status[2:0] entry_index[9:3] entry_type[17:10]
//         |     | live_count[25:18], pad to 32                        | -
// After reset, a clearing pass over every slot empties the slot table.
// Each item is first hashed in the shared hash unit, then probed from its home slot.
// An add then scans from the home slot again for an empty slot.
// Remove then rehashes each occupied slot after the hole, up to the next empty one.
// Handle 0, or an add to a full store, skips the probing. The next word is taken
// once the result has left the output register.
module handle_hash_table_core
  import hht_pkg::*;
#(
  parameter int SLOT_COUNT  = 256,
  parameter int NUM_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // mode, handle, res_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status, entry_index, entry_type, live_count
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int SCW = $clog2(SLOT_COUNT + 1);

  logic [EW:0]  slot_mem [SLOT_COUNT];
  logic [31:0]  key_mem  [NUM_ENTRIES];
  logic [7:0]   type_mem [NUM_ENTRIES];
  logic [EW:0]  link_mem [NUM_ENTRIES];

  state_t state, state_next;
  logic [1:0]  mode;
  logic [31:0] handle;
  logic [7:0]  res_type;
  logic [EW:0] free_top;
  logic [CW-1:0] used_total;
  logic [SW-1:0] base, pos, hole, kslot;
  logic [SCW-1:0] cnt;
  logic [EW:0]  rd_e, ent;
  logic [31:0]  rd_key;
  logic [7:0]   rd_type;
  logic [EW:0]  rd_link;
  logic         hstart;
  hash_ctl_t    hctl;
  logic [31:0]  hval;
  logic [31:0]  hkey;
  logic [2:0]   o_status;
  logic [6:0]   o_idx;
  logic [7:0]   o_type;
  logic         empty_e, mv;

  hht_hash u_hash (.clk(clk), .rst(rst), .start(hstart), .key(hkey), .ctl(hctl), .hash(hval));

  assign hkey = (state == S_HASH) ? handle : rd_key;
  assign empty_e = rd_e[EW];
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    if (pos > hole) mv = (kslot <= hole) || (kslot > pos);
    else            mv = (kslot <= hole) && (kslot > pos);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (cnt == SCW'(SLOT_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:     if (s_axis_tvalid && s_axis_tready) state_next = S_HASH;
      S_HASH: begin
        if (handle == 32'd0) state_next = S_DONE;
        else if (mode == MODE_ADD && (free_top[EW] || SCW'(used_total) >= SCW'(SLOT_COUNT)))
          state_next = S_DONE;
        else if (!hctl.busy && cnt != '0) state_next = S_FIND_RD;
      end
      S_FIND_RD:  state_next = S_FIND_KEY;
      S_FIND_KEY: state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (empty_e || cnt == SCW'(SLOT_COUNT))
          state_next = (mode == MODE_ADD) ? S_INS_RD : S_DONE;
        else if (rd_key == handle)
          state_next = (mode == MODE_REMOVE) ? S_DEL_RD : S_DONE;
        else state_next = S_FIND_RD;
      end
      S_INS_RD:   state_next = S_INS_CHK;
      S_INS_CHK:  if (empty_e) state_next = S_DONE; else state_next = S_INS_RD;
      S_DEL_RD:   state_next = S_DEL_KEY;
      S_DEL_KEY:  state_next = (empty_e || cnt == SCW'(SLOT_COUNT)) ? S_DONE : S_DEL_LOAD;
      S_DEL_LOAD: state_next = S_DEL_HASH;
      S_DEL_HASH: if (!hctl.busy) state_next = S_DEL_CHK;
      S_DEL_CHK:  state_next = S_DEL_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    hstart = 1'b0;
    unique case (state)
      S_HASH:     hstart = (cnt == '0);
      S_DEL_LOAD: hstart = 1'b1;
      default:    hstart = 1'b0;
    endcase
  end

  // rd_e/rd_key/rd_type registered reads
  always_ff @(posedge clk) begin
    rd_e <= slot_mem[pos];
    rd_key <= key_mem[rd_e[EW-1:0]];
    rd_type <= type_mem[rd_e[EW-1:0]];
    rd_link <= link_mem[free_top[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      free_top <= '0;
      used_total <= '0;
      m_axis_tvalid <= 1'b0;
      pos <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          slot_mem[cnt[SW-1:0]] <= {1'b1, EW'(0)};
          if (cnt < SCW'(NUM_ENTRIES)) begin
            link_mem[cnt[EW-1:0]] <= (cnt == SCW'(NUM_ENTRIES - 1)) ? {1'b1, EW'(0)}
                                                                     : (EW+1)'(cnt + 1'b1);
          end
          cnt <= (cnt == SCW'(SLOT_COUNT - 1)) ? '0 : cnt + 1'b1;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          mode <= s_axis_tdata[1:0];
          handle <= s_axis_tdata[33:2];
          res_type <= s_axis_tdata[41:34];
          cnt <= '0;
          o_status <= ST_OK; o_idx <= '0; o_type <= '0;
        end
        S_HASH: begin
          if (handle == 32'd0) o_status <= ST_INVALID;
          else if (mode == MODE_ADD && (free_top[EW] ||
                   SCW'(used_total) >= SCW'(SLOT_COUNT))) o_status <= ST_FULL;
          else if (cnt == '0) cnt <= SCW'(1);
          else if (!hctl.busy) begin
            base <= hval[SW-1:0];
            pos <= hval[SW-1:0];
            cnt <= '0;
          end
        end
        S_FIND_RD: ;
        S_FIND_KEY: ;
        S_FIND_CHK: begin
          ent <= rd_e;
          if (empty_e || cnt == SCW'(SLOT_COUNT)) begin
            if (mode != MODE_ADD) o_status <= ST_MISSING;
            pos <= base;
          end else if (rd_key == handle) begin
            if (mode == MODE_ADD) o_status <= ST_DUP;
            else begin
              o_idx <= 7'(rd_e[EW-1:0]);
              o_type <= rd_type;
            end
            if (mode == MODE_REMOVE) begin
              link_mem[rd_e[EW-1:0]] <= free_top;
              free_top <= rd_e;
              used_total <= used_total - 1'b1;
              hole <= pos;
              pos <= pos + 1'b1;
              cnt <= SCW'(1);
            end
          end else begin
            pos <= pos + 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        S_INS_RD: ;
        S_INS_CHK: begin
          if (empty_e) begin
            slot_mem[pos] <= free_top;
            key_mem[free_top[EW-1:0]] <= handle;
            type_mem[free_top[EW-1:0]] <= res_type;
            free_top <= rd_link;
            used_total <= used_total + 1'b1;
            o_idx <= 7'(free_top[EW-1:0]);
            o_type <= res_type;
          end else pos <= pos + 1'b1;
        end
        S_DEL_RD: ;
        S_DEL_KEY: begin
          ent <= rd_e;
          if (empty_e || cnt == SCW'(SLOT_COUNT)) slot_mem[hole] <= {1'b1, EW'(0)};
        end
        S_DEL_LOAD: ;
        S_DEL_HASH: if (!hctl.busy) kslot <= hval[SW-1:0];
        S_DEL_CHK: begin
          if (mv) begin
            slot_mem[hole] <= ent;
            hole <= pos;
          end
          pos <= pos + 1'b1;
          cnt <= cnt + 1'b1;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, 8'(used_total), o_type, o_idx, o_status};

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_count: assert property (@(posedge clk) disable iff (rst)
    SCW'(used_total) <= SCW'(NUM_ENTRIES)) else $error("count overflow");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_status != ST_OK) |-> (o_idx == '0 && o_type == '0))
    else $error("index on error");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while waiting");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb
  import hht_pkg::*;
();

  localparam int SLOTS   = 256;
  localparam int ENTRIES = 128;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] handle;
    logic [7:0]  res_type;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  idx;
    logic [7:0]  etype;
    logic [7:0]  live;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  handle_hash_table_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  bit     hold_off = 1'b0;
  bit     in_hs = 1'b0;
  int     quiet_cycles = 0;
  int     n_queued = 0;
  int     n_checked = 0;

  // shadow table
  int          slot_tab[SLOTS];
  logic [31:0] keys[ENTRIES];
  logic [7:0]  types[ENTRIES];
  bit          used[ENTRIES];
  int          links[ENTRIES];
  int          head;
  int          live;
  logic [31:0] live_keys[$];

  function automatic int home_of(logic [31:0] key);
    logic [31:0] h;
    h = key;
    h = ((h >> 16) ^ h) * HASH_MUL;
    h = ((h >> 16) ^ h) * HASH_MUL;
    h = (h >> 16) ^ h;
    return int'(h % SLOTS);
  endfunction

  function automatic int slot_of(logic [31:0] key);
    int b, s, e;
    b = home_of(key);
    for (int p = 0; p < SLOTS; p++) begin
      s = (b + p) % SLOTS;
      e = slot_tab[s];
      if (e >= ENTRIES) return SLOTS;
      if (used[e] && keys[e] == key) return s;
    end
    return SLOTS;
  endfunction

  function automatic void close_gap(int hole);
    int i, j, e, k;
    bit mv;
    i = hole;
    j = hole;
    for (int n = 1; n < SLOTS; n++) begin
      j = (j + 1) % SLOTS;
      e = slot_tab[j];
      if (e >= ENTRIES) break;
      k = home_of(keys[e]);
      if (j > i) mv = (k <= i) || (k > j);
      else mv = (k <= i) && (k > j);
      if (mv) begin
        slot_tab[i] = e;
        i = j;
      end
    end
    slot_tab[i] = ENTRIES;
  endfunction

  function automatic reply_t apply_op(op_t op);
    reply_t r;
    int s, b, x;
    r = '0;
    r.status = ST_OK;
    if (op.handle == 0) begin
      r.status = ST_INVALID;
    end else if (op.mode == MODE_ADD) begin
      if (head >= ENTRIES || live >= SLOTS) begin
        r.status = ST_FULL;
      end else if (slot_of(op.handle) < SLOTS) begin
        r.status = ST_DUP;
      end else begin
        b = home_of(op.handle);
        x = head;
        head = links[x];
        keys[x] = op.handle;
        types[x] = op.res_type;
        used[x] = 1'b1;
        for (int p = 0; p < SLOTS; p++) begin
          s = (b + p) % SLOTS;
          if (slot_tab[s] >= ENTRIES) begin
            slot_tab[s] = x;
            break;
          end
        end
        live++;
        live_keys.push_back(op.handle);
        r.idx = x[6:0];
        r.etype = op.res_type;
      end
    end else begin
      s = slot_of(op.handle);
      if (s >= SLOTS) begin
        r.status = ST_MISSING;
      end else begin
        x = slot_tab[s];
        r.idx = x[6:0];
        r.etype = types[x];
        if (op.mode == MODE_REMOVE) begin
          used[x] = 1'b0;
          keys[x] = '0;
          links[x] = head;
          head = x;
          close_gap(s);
          if (live > 0) live--;
          foreach (live_keys[q]) if (live_keys[q] == op.handle) begin
            live_keys.delete(q);
            break;
          end
        end
      end
    end
    r.live = live[7:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_hs) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tdata <= {6'd0, pending_ops.pop_front()} ;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // s_axis_tdata packing: res_type lowest in op_t, so reorder to port layout
  op_t    taken;
  reply_t got, want;
  always @(posedge clk) begin
    in_hs <= s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        taken.mode = mode_t'(s_axis_tdata[1:0]);
        taken.handle = s_axis_tdata[33:2];
        taken.res_type = s_axis_tdata[41:34];
        expected_replies.push_back(apply_op(taken));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        got.status = status_t'(m_axis_tdata[2:0]);
        got.idx = m_axis_tdata[9:3];
        got.etype = m_axis_tdata[17:10];
        got.live = m_axis_tdata[25:18];
        if (expected_replies.size() == 0) begin
          report("unexpected word", m_axis_tdata, 32'd0);
        end else begin
          want = expected_replies.pop_front();
          if (got.status != want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.idx != want.idx) report("entry_index", 32'(got.idx), 32'(want.idx));
          if (got.etype != want.etype)
            report("entry_type", 32'(got.etype), 32'(want.etype));
          if (got.live != want.live) report("live_count", 32'(got.live), 32'(want.live));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic op_t port_word(mode_t m, logic [31:0] h, logic [7:0] t);
    logic [47:0] w;
    w = {6'd0, t, h, m};
    return op_t'(w[41:0]);
  endfunction

  task automatic queue_op(mode_t m, logic [31:0] h, logic [7:0] t);
    n_queued++;
    pending_ops.push_back(port_word(m, h, t));
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (live_keys.size() > 0 && r < 55) return live_keys[$urandom_range(live_keys.size() - 1)];
    if (r < 60) return 32'd0;
    if (r < 70) return $urandom_range(300, 1);
    return $urandom;
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    int r;
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      queue_op(r < 45 ? MODE_ADD : r < 65 ? MODE_LOOKUP : r < 97 ? MODE_REMOVE : MODE_SPARE,
               pick_key(), 8'($urandom));
      wait (pending_ops.size() < 4);
    end
    wait (pending_ops.size() == 0);
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) slot_tab[s] = ENTRIES;
    for (int e = 0; e < ENTRIES; e++) begin
      keys[e] = '0;
      types[e] = '0;
      used[e] = 1'b0;
      links[e] = e + 1;
    end
    head = 0;
    live = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_op(MODE_ADD, 32'd0, 8'hff);
    queue_op(MODE_LOOKUP, 32'd0, 8'h00);
    queue_op(MODE_REMOVE, 32'd0, 8'h00);
    queue_op(MODE_LOOKUP, 32'hffff_ffff, 8'h00);
    queue_op(MODE_REMOVE, 32'd1, 8'h00);
    queue_op(MODE_ADD, 32'hffff_ffff, 8'hff);
    queue_op(MODE_ADD, 32'd1, 8'h00);
    queue_op(MODE_ADD, 32'd1, 8'h5a);
    queue_op(MODE_SPARE, 32'd1, 8'h00);
    queue_op(MODE_LOOKUP, 32'hffff_ffff, 8'h00);
    queue_op(MODE_ADD, 32'h8000_0000, 8'haa);
    queue_op(MODE_ADD, 32'h5555_5555, 8'h55);
    queue_op(MODE_REMOVE, 32'd1, 8'h00);
    queue_op(MODE_LOOKUP, 32'h8000_0000, 8'h00);
    queue_op(MODE_REMOVE, 32'hffff_ffff, 8'h00);
    queue_op(MODE_REMOVE, 32'hffff_ffff, 8'h00);
    queue_op(MODE_ADD, 32'haaaa_aaaa, 8'h81);
    wait (pending_ops.size() == 0);

    // fill to store full, with a long output hold-off
    hold_off = 1'b1;
    for (int k = 0; k < 135; k++) queue_op(MODE_ADD, $urandom, 8'($urandom));
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    wait (pending_ops.size() == 0);
    for (int k = 0; k < 140; k++) queue_op(MODE_REMOVE, live_keys.size() > k ?
                                          live_keys[k] : 32'h1234_5678, 8'h00);
    wait (pending_ops.size() == 0);

    run_phase(350, 0, 0);
    run_phase(350, 61, 0);
    run_phase(350, 0, 61);
    run_phase(350, 27, 27);
    idle_pct = 0;
    stall_pct = 0;
    wait (n_checked == n_queued);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hht_pkg.sv
sv/hht_hash.sv
sv/handle_hash_table_core.sv
sim/tb.sv
